>>> rtl/core/ctok_pkg.sv
// types and constants shared by the command tokenizer modules
`timescale 1ns / 1ps
package ctok_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [1:0] KIND_BYTE       = 2'd0;
   localparam logic [1:0] KIND_END_TOKEN  = 2'd1;
   localparam logic [1:0] KIND_END_STREAM = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   typedef enum logic [2:0] {
      MODE_NONE          = 3'd0,
      MODE_COMMENT       = 3'd1,
      MODE_STRING        = 3'd2,
      MODE_WORD          = 3'd3,
      MODE_AFTER_STRING  = 3'd4,
      MODE_AFTER_COMMENT = 3'd5,
      MODE_ESCAPE        = 3'd6
   } mode_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] char_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  token_byte;
      logic [15:0] line_number;
      logic [15:0] column_number;
      logic        last;
   } rsp_word_type;

   // outcome of one pass over a character
   typedef struct packed {
      mode_type        mode;
      logic            reproc;
      logic [1:0]      count;
      logic [1:0][1:0] kinds;
      logic [1:0][7:0] bytes;
   } step_type;

   // all words caused by one accepted item
   typedef struct packed {
      logic [1:0]      last_idx;
      logic [3:0][1:0] kinds;
      logic [3:0][7:0] bytes;
      logic [15:0]     line_number;
      logic [15:0]     column_number;
   } bundle_type;

endpackage

>>> rtl/core/ctok_front.sv
// front end: lexer state, position counters and word classification
`timescale 1ns / 1ps
module ctok_front #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ctok_pkg::req_word_type req_word,
   output logic                  push,
   output ctok_pkg::bundle_type  push_bundle
);
   import ctok_pkg::*;

   mode_type                   mode_ff, mode_in;
   logic [POSITION_BITS-1:0]   line_ff, line_in;
   logic [POSITION_BITS-1:0]   col_ff, col_in;
   step_type                   pass1, pass2;
   logic [2:0]                 total;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c inside {[8'd33:8'd126]}) && !is_alnum(c);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
   endfunction

   function automatic step_type handle_char(input mode_type mode, input logic [7:0] c);
      step_type s;
      s = '0;
      s.mode = mode;
      case (mode)
         MODE_COMMENT: begin
            if (c == CH_NEWLINE) s.mode = MODE_NONE;
         end
         MODE_STRING: begin
            if (c == CH_QUOTE) begin
               s.mode = MODE_AFTER_STRING;
            end else begin
               if (c == CH_BACKSLASH) s.mode = MODE_ESCAPE;
               s.count    = 2'd1;
               s.kinds[0] = KIND_BYTE;
               s.bytes[0] = c;
            end
         end
         MODE_WORD: begin
            if (is_alnum(c) || c == CH_DOT) begin
               s.count    = 2'd1;
               s.kinds[0] = KIND_BYTE;
               s.bytes[0] = to_lower(c);
            end else begin
               s.count    = 2'd1;
               s.kinds[0] = KIND_END_TOKEN;
               s.mode     = MODE_NONE;
               s.reproc   = 1'b1;
            end
         end
         MODE_AFTER_STRING: begin
            if (c == CH_QUOTE) begin
               s.mode = MODE_STRING;
            end else if (c == CH_HASH) begin
               s.mode = MODE_AFTER_COMMENT;
            end else if (!is_space(c)) begin
               s.count    = 2'd2;
               s.kinds[0] = KIND_BYTE;
               s.bytes[0] = CH_QUOTE;
               s.kinds[1] = KIND_END_TOKEN;
               s.mode     = MODE_NONE;
               s.reproc   = 1'b1;
            end
         end
         MODE_AFTER_COMMENT: begin
            if (c == CH_NEWLINE) s.mode = MODE_AFTER_STRING;
         end
         MODE_ESCAPE: begin
            s.count    = 2'd1;
            s.kinds[0] = KIND_BYTE;
            s.bytes[0] = c;
            s.mode     = MODE_STRING;
         end
         default: begin
            s.mode = MODE_NONE;
            if (is_space(c)) begin
               s.mode = MODE_NONE;
            end else if (c == CH_HASH) begin
               s.mode = MODE_COMMENT;
            end else if (c == CH_QUOTE) begin
               s.count    = 2'd1;
               s.kinds[0] = KIND_BYTE;
               s.bytes[0] = c;
               s.mode     = MODE_STRING;
            end else if (is_punct(c) && c != CH_PLUS && c != CH_MINUS) begin
               s.count    = 2'd2;
               s.kinds[0] = KIND_BYTE;
               s.bytes[0] = c;
               s.kinds[1] = KIND_END_TOKEN;
            end else begin
               s.count    = 2'd1;
               s.kinds[0] = KIND_BYTE;
               s.bytes[0] = to_lower(c);
               s.mode     = MODE_WORD;
            end
         end
      endcase
      return s;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         line_ff <= POSITION_BITS'(1);
         col_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      push        = 1'b0;
      push_bundle = '0;
      total       = 3'd0;
      pass1       = handle_char(mode_ff, req_word.char_byte);
      pass2       = handle_char(MODE_NONE, req_word.char_byte);
      if (!pass1.reproc) pass2.count = 2'd0;

      if (accept) begin
         if (req_word.operation == OP_END) begin
            mode_in              = MODE_NONE;
            push                 = 1'b1;
            push_bundle.kinds[0] = KIND_END_STREAM;
            push_bundle.last_idx = 2'd0;
         end else begin
            if (col_ff != '1) col_in = col_ff + 1'b1;
            if (req_word.char_byte == CH_NEWLINE) begin
               col_in = '0;
               if (line_ff != '1) line_in = line_ff + 1'b1;
            end
            for (int i = 0; i < 2; i++) begin
               if (2'(i) < pass1.count) begin
                  push_bundle.kinds[i] = pass1.kinds[i];
                  push_bundle.bytes[i] = pass1.bytes[i];
               end
            end
            for (int j = 0; j < 2; j++) begin
               if (2'(j) < pass2.count) begin
                  push_bundle.kinds[2'(pass1.count + 2'(j))] = pass2.kinds[j];
                  push_bundle.bytes[2'(pass1.count + 2'(j))] = pass2.bytes[j];
               end
            end
            total                = 3'(pass1.count) + 3'(pass2.count);
            push                 = (total != 3'd0);
            push_bundle.last_idx = 2'(total - 3'd1);
            mode_in              = pass1.reproc ? pass2.mode : pass1.mode;
         end
      end
      push_bundle.line_number   = 16'(line_in);
      push_bundle.column_number = 16'(col_in);
   end

endmodule

>>> rtl/core/ctok_queue.sv
// short queue of word bundles between front and back
`timescale 1ns / 1ps
module ctok_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ctok_pkg::bundle_type push_bundle,
   output logic                 full,
   input  logic                 pop,
   output logic                 nonempty,
   output ctok_pkg::bundle_type head
);
   import ctok_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type             entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_bundle;
   end

endmodule

>>> rtl/core/ctok_back.sv
// back end: unpacks bundles into result words behind an output register
`timescale 1ns / 1ps
module ctok_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   nonempty,
   input  ctok_pkg::bundle_type   head,
   output logic                   pop,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output ctok_pkg::rsp_word_type rsp_word
);
   import ctok_pkg::*;

   logic         valid_ff, valid_in;
   logic [1:0]   idx_ff, idx_in;
   rsp_word_type rsp_ff, rsp_in;
   logic         load;

   assign load      = nonempty && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      rsp_in               = rsp_ff;
      idx_in               = idx_ff;
      valid_in             = valid_ff;
      pop                  = 1'b0;
      if (valid_ff && rsp_pop) valid_in = 1'b0;
      if (load) begin
         valid_in             = 1'b1;
         rsp_in.kind          = head.kinds[idx_ff];
         rsp_in.token_byte    = head.bytes[idx_ff];
         rsp_in.line_number   = head.line_number;
         rsp_in.column_number = head.column_number;
         rsp_in.last          = (idx_ff == head.last_idx);
         if (idx_ff == head.last_idx) begin
            pop    = 1'b1;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/core/command_tokenizer.sv
// top level of the command tokenizer
// an item's bundle is first written into the queue, then each word into the output register
// throughput: one item per cycle while the queue is not full; the back end delivers
// one word per cycle while the output is empty or popped, so items that cause two to
// four words back up and a four-bundle queue absorbs the burst before full is raised
// reset: lexer in no-token mode, line 1, column 0, queue and output empty
`timescale 1ns / 1ps
module command_tokenizer #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  ctok_pkg::req_word_type req_word,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output ctok_pkg::rsp_word_type rsp_word
);
   import ctok_pkg::*;

   logic       accept;
   logic       push;
   logic       q_full;
   logic       q_nonempty;
   logic       q_pop;
   bundle_type push_bundle;
   bundle_type head;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   ctok_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_word   (req_word),
      .push       (push),
      .push_bundle(push_bundle)
   );

   ctok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_bundle(push_bundle),
      .full       (q_full),
      .pop        (q_pop),
      .nonempty   (q_nonempty),
      .head       (head)
   );

   ctok_back u_back (
      .clock    (clock),
      .reset    (reset),
      .nonempty (q_nonempty),
      .head     (head),
      .pop      (q_pop),
      .rsp_pop  (rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_word (rsp_word)
   );

endmodule

>>> rtl/core/ctok_checker.sv
// port-level checks for the command tokenizer, bound to the top level
`timescale 1ns / 1ps
module ctok_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_pop,
   input logic                   rsp_empty,
   input ctok_pkg::rsp_word_type rsp_word
);
   import ctok_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue or output not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("waiting word changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word.kind != 2'd3)
      else $error("illegal word kind");

   a_stream_end_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.kind == KIND_END_STREAM |-> rsp_word.last
         && rsp_word.token_byte == 8'd0)
      else $error("end of stream not a lone word");

   a_mark_no_byte: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.kind == KIND_END_TOKEN |-> rsp_word.token_byte == 8'd0)
      else $error("end-of-token mark carries a byte");

endmodule

bind command_tokenizer ctok_checker u_checker (.*);
